@@ rtl/bgra_pkg.sv @@
// Shared constants and types for the BMP pixel to BGRA converter.
package bgra_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned ShiftBits = $clog2(WordBits);
  localparam int unsigned ChanBits  = 8;
  localparam int unsigned CfgIdxBits = 3;

  // One register stage before the lanes, three setup stages in each lane,
  // then one divider stage per quotient bit.
  localparam int unsigned SetupStages = 3;
  localparam int unsigned DivStages   = WordBits;
  localparam int unsigned Latency     = 1 + SetupStages + DivStages;

  localparam logic [WordBits-1:0] Red555Mask   = 32'h0000_7C00;
  localparam logic [WordBits-1:0] Green555Mask = 32'h0000_03E0;
  localparam logic [WordBits-1:0] Blue555Mask  = 32'h0000_001F;
  localparam logic [WordBits-1:0] ByteMask0    = 32'h0000_00FF;
  localparam logic [WordBits-1:0] ByteMask1    = 32'h0000_FF00;
  localparam logic [WordBits-1:0] ByteMask2    = 32'h00FF_0000;
  localparam logic [WordBits-1:0] ByteMask3    = 32'hFF00_0000;
  localparam logic [WordBits-1:0] Keep16Mask   = 32'h0000_FFFF;
  localparam logic [WordBits-1:0] Keep24Mask   = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    Size16 = 2'd0,
    Size24 = 2'd1,
    Size32 = 2'd2,
    Size32Alt = 2'd3
  } size_code_t;

  typedef enum logic [CfgIdxBits-1:0] {
    RegPixelSize = 3'd0,
    RegBitfield  = 3'd1,
    RegRedMask   = 3'd2,
    RegGreenMask = 3'd3,
    RegBlueMask  = 3'd4,
    RegAlphaMask = 3'd5
  } cfg_reg_t;

endpackage

@@ rtl/bgra_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, low byte kept.
module bgra_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic [bgra_pkg::WordBits-1:0]      dividend,
  input  logic [bgra_pkg::WordBits-1:0]      divisor,
  input  logic                               zero,
  output logic [bgra_pkg::ChanBits-1:0]      quotient
);

  localparam int unsigned W = bgra_pkg::WordBits;
  localparam int unsigned N = bgra_pkg::DivStages;
  localparam int unsigned Q = bgra_pkg::ChanBits;

  logic [W-1:0] rem_r  [1:N];
  logic [W-1:0] dvd_r  [1:N];
  logic [W-1:0] dsr_r  [1:N];
  logic [Q-1:0] quo_r  [1:N];
  logic         zero_r [1:N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [W-1:0] rem_in;
      logic [W-1:0] dvd_in;
      logic [W-1:0] dsr_in;
      logic [Q-1:0] quo_in;
      logic         zero_in;
      logic [W:0]   r_sh;
      logic [W+1:0] diff;
      logic         ge;

      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign dvd_in  = dividend;
        assign dsr_in  = divisor;
        assign quo_in  = '0;
        assign zero_in = zero;
      end else begin : g_next
        assign rem_in  = rem_r[k];
        assign dvd_in  = dvd_r[k];
        assign dsr_in  = dsr_r[k];
        assign quo_in  = quo_r[k];
        assign zero_in = zero_r[k];
      end

      assign r_sh = {rem_in, dvd_in[W-1]};
      assign diff = {1'b0, r_sh} - {2'b00, dsr_in};
      assign ge   = ~diff[W+1];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1]  <= ge ? diff[W-1:0] : r_sh[W-1:0];
          dvd_r[k+1]  <= {dvd_in[W-2:0], 1'b0};
          dsr_r[k+1]  <= dsr_in;
          quo_r[k+1]  <= {quo_in[Q-2:0], ge};
          zero_r[k+1] <= zero_in;
        end
      end
    end
  endgenerate

  // Empty mask reads as zero; the divide by zero result is discarded.
  assign quotient = zero_r[N] ? '0 : quo_r[N];

endmodule

@@ rtl/bgra_lane.sv @@
// One color channel: mask alignment, scale by 255 and divide by the mask.
module bgra_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [bgra_pkg::WordBits-1:0]  pix,
  input  logic [bgra_pkg::WordBits-1:0]  mask,
  output logic [bgra_pkg::ChanBits-1:0]  chan
);

  localparam int unsigned W = bgra_pkg::WordBits;
  localparam int unsigned S = bgra_pkg::ShiftBits;

  logic [S-1:0] tz;

  // Stage 1 registers
  logic [W-1:0] pm1;
  logic [W-1:0] mask1;
  logic [S-1:0] tz1;
  logic         zero1;
  // Stage 2 registers
  logic [W-1:0] val2;
  logic [W-1:0] m2;
  logic         zero2;
  // Stage 3 registers
  logic [W-1:0] prod3;
  logic [W-1:0] m3;
  logic         zero3;

  always_comb begin
    tz = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        tz = S'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm1   <= pix & mask;
      mask1 <= mask;
      tz1   <= tz;
      zero1 <= (mask == '0);

      val2  <= pm1 >> tz1;
      m2    <= mask1 >> tz1;
      zero2 <= zero1;

      // val * 255, wrapped to the word width
      prod3 <= {val2[W-9:0], 8'h00} - val2;
      m3    <= m2;
      zero3 <= zero2;
    end
  end

  bgra_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (prod3),
    .divisor  (m3),
    .zero     (zero3),
    .quotient (chan)
  );

endmodule

@@ rtl/bmp_pixel_to_bgra.sv @@
// Top level of the BMP pixel to BGRA converter.
// Takes one raw BMP pixel per beat and offers its blue, green, red and alpha
// bytes once the pixel has passed the pipeline. The path has 36 register
// stages: one input stage, three mask-alignment and scaling stages, then a
// 32-stage pipelined divider per channel, one quotient bit per stage. A new
// pixel is taken every cycle while the output side takes results;
// when the output beat is held, the whole pipeline holds with it. The 24 and
// 32 bit direct modes run through the same path using byte masks, which scale
// to the byte unchanged. Configuration writes take effect at once and belong
// in gaps where the pipeline is empty.
module bmp_pixel_to_bgra (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bgra_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [bgra_pkg::WordBits-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bgra_pkg::WordBits-1:0]        pixel_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bgra_pkg::ChanBits-1:0]        blue_out,
  output logic [bgra_pkg::ChanBits-1:0]        green_out,
  output logic [bgra_pkg::ChanBits-1:0]        red_out,
  output logic [bgra_pkg::ChanBits-1:0]        alpha_out
);

  localparam int unsigned W   = bgra_pkg::WordBits;
  localparam int unsigned Lat = bgra_pkg::Latency;

  bgra_pkg::size_code_t size_code;
  logic                 bitfield_mode;
  logic [W-1:0]         red_mask;
  logic [W-1:0]         green_mask;
  logic [W-1:0]         blue_mask;
  logic [W-1:0]         alpha_mask;

  logic         en;
  logic [Lat-1:0] valid;

  logic [W-1:0] pix_keep;
  logic [W-1:0] r_sel, g_sel, b_sel, a_sel;
  logic [W-1:0] pix0;
  logic [W-1:0] r_mask0, g_mask0, b_mask0, a_mask0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_code     <= bgra_pkg::Size32;
      bitfield_mode <= 1'b0;
      red_mask      <= '0;
      green_mask    <= '0;
      blue_mask     <= '0;
      alpha_mask    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bgra_pkg::RegPixelSize: size_code     <= bgra_pkg::size_code_t'(cfg_data[1:0]);
        bgra_pkg::RegBitfield:  bitfield_mode <= cfg_data[0];
        bgra_pkg::RegRedMask:   red_mask      <= cfg_data;
        bgra_pkg::RegGreenMask: green_mask    <= cfg_data;
        bgra_pkg::RegBlueMask:  blue_mask     <= cfg_data;
        bgra_pkg::RegAlphaMask: alpha_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (size_code)
      bgra_pkg::Size16: pix_keep = pixel_word & bgra_pkg::Keep16Mask;
      bgra_pkg::Size24: pix_keep = pixel_word & bgra_pkg::Keep24Mask;
      default:          pix_keep = pixel_word;
    endcase

    if (bitfield_mode) begin
      r_sel = red_mask;
      g_sel = green_mask;
      b_sel = blue_mask;
      a_sel = alpha_mask;
    end else if (size_code == bgra_pkg::Size16) begin
      r_sel = bgra_pkg::Red555Mask;
      g_sel = bgra_pkg::Green555Mask;
      b_sel = bgra_pkg::Blue555Mask;
      a_sel = '0;
    end else begin
      // byte picks: a byte mask scales to the byte itself
      r_sel = bgra_pkg::ByteMask2;
      g_sel = bgra_pkg::ByteMask1;
      b_sel = bgra_pkg::ByteMask0;
      a_sel = (size_code == bgra_pkg::Size24) ? '0 : bgra_pkg::ByteMask3;
    end
  end

  assign en       = ~valid[Lat-1] | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[Lat-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0    <= pix_keep;
      r_mask0 <= r_sel;
      g_mask0 <= g_sel;
      b_mask0 <= b_sel;
      a_mask0 <= a_sel;
    end
  end

  bgra_lane u_red   (.clk(clk), .en(en), .pix(pix0), .mask(r_mask0), .chan(red_out));
  bgra_lane u_green (.clk(clk), .en(en), .pix(pix0), .mask(g_mask0), .chan(green_out));
  bgra_lane u_blue  (.clk(clk), .en(en), .pix(pix0), .mask(b_mask0), .chan(blue_out));
  bgra_lane u_alpha (.clk(clk), .en(en), .pix(pix0), .mask(a_mask0), .chan(alpha_out));

  assign out_valid = valid[Lat-1];

endmodule

@@ rtl/bgra_checker.sv @@
// Port-level checks for the BMP pixel to BGRA converter, bound to the top.
module bgra_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [bgra_pkg::ChanBits-1:0]       blue_out,
  input logic [bgra_pkg::ChanBits-1:0]       green_out,
  input logic [bgra_pkg::ChanBits-1:0]       red_out,
  input logic [bgra_pkg::ChanBits-1:0]       alpha_out
);

  // A held result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blue_out) && $stable(green_out)
      && $stable(red_out) && $stable(alpha_out))
    else $error("output beat changed while stalled");

  // Input side stalls only behind a held result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // Pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  // First cycle out of reset shows no result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result beat while pipeline flushing from reset");

endmodule

bind bmp_pixel_to_bgra bgra_checker u_bgra_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .blue_out  (blue_out),
  .green_out (green_out),
  .red_out   (red_out),
  .alpha_out (alpha_out)
);
